>>> sv/ghst_pkg.sv
// Package: types, constants and helpers for the generational handle slot table.
package ghst_pkg;

   localparam int SLOT_COUNT = 64;
   localparam int GEN_BITS   = 16;
   localparam int POS_W      = $clog2(SLOT_COUNT);
   localparam int IDX_W      = 7;
   localparam int ACT_W      = 2;
   localparam int STS_W      = 2;

   typedef enum logic [ACT_W-1:0] {
      ACT_CREATE   = 2'd0,
      ACT_DESTROY  = 2'd1,
      ACT_VALIDATE = 2'd2,
      ACT_CLEAR    = 2'd3
   } action_type;

   typedef enum logic [STS_W-1:0] {
      STS_OK      = 2'd0,
      STS_INVALID = 2'd1,
      STS_KIND    = 2'd2,
      STS_FULL    = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] pos;
   } free_type;

   // lowest clear bit of the occupancy vector
   function automatic free_type first_free(input logic [SLOT_COUNT-1:0] occ);
      free_type res;
      res.found = 1'b0;
      res.pos   = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!occ[i]) begin
            res.found = 1'b1;
            res.pos   = POS_W'(i);
         end
      end
      return res;
   endfunction

endpackage

>>> sv/ghst_if.sv
// Interfaces: request and response channels of the slot table.
interface ghst_req_if;
   logic                          valid;
   logic                          ready;
   logic [ghst_pkg::ACT_W-1:0]    action;
   logic [ghst_pkg::IDX_W-1:0]    slot_index;
   logic [ghst_pkg::GEN_BITS-1:0] slot_generation;
   logic                          kind;
   logic                          check_kind;

   modport source (output valid, action, slot_index, slot_generation, kind, check_kind,
                   input ready);
   modport sink   (input valid, action, slot_index, slot_generation, kind, check_kind,
                   output ready);
endinterface

interface ghst_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ghst_pkg::STS_W-1:0]    status;
   logic [ghst_pkg::IDX_W-1:0]    handle_index;
   logic [ghst_pkg::GEN_BITS-1:0] handle_generation;

   modport source (output valid, status, handle_index, handle_generation, input ready);
   modport sink   (input valid, status, handle_index, handle_generation, output ready);
endinterface

>>> sv/generational_handle_slot_table_top.sv
// Top level: generational handle slot table with slot memories and occupancy flags.
//
//   channel    dir  handshake          payload
//   req_chan   in   valid / ready      action, slot_index, slot_generation, kind, check_kind
//   rsp_chan   out  valid / ready      status, handle_index, handle_generation
//
// Each transaction passes an accept cycle, which reads the slot's generation and kind
// memories, and an execute state, which checks the handle and writes back.
// A waiting response holds the block in execute until it is taken.
// Reset is synchronous and clears occupancy and generation-valid flags;
// an unwritten generation reads as one.
module generational_handle_slot_table_top (
   input  logic          clock,
   input  logic          reset,
   ghst_req_if.sink      req_chan,
   ghst_rsp_if.source    rsp_chan
);

   localparam int PW = ghst_pkg::POS_W;
   localparam int IW = ghst_pkg::IDX_W;
   localparam int GW = ghst_pkg::GEN_BITS;
   localparam int SC = ghst_pkg::SLOT_COUNT;

   logic [GW-1:0] gen_mem  [SC];
   logic          kind_mem [SC];

   ghst_pkg::state_type  state_ff, state_in;
   logic [SC-1:0]        occupied_ff, occupied_in;
   logic [SC-1:0]        gen_vld_ff, gen_vld_in;

   ghst_pkg::action_type action_ff;
   logic [PW-1:0]        pos_ff;
   logic [GW-1:0]        gen_ff;
   logic                 kind_ff, check_ff, in_range_ff, full_ff;
   logic [GW-1:0]        gen_rd_ff;
   logic                 kind_rd_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   ghst_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [IW-1:0]        rsp_idx_ff, rsp_idx_in;
   logic [GW-1:0]        rsp_gen_ff, rsp_gen_in;

   logic                 accept, exec_fire, req_ready;
   ghst_pkg::free_type   free_slot;
   logic [PW-1:0]        rd_addr;
   logic [GW-1:0]        gen_cur, gen_next;
   logic                 handle_ok;
   logic                 wr_gen, wr_kind;

   assign accept = req_chan.valid && req_ready;
   assign free_slot = ghst_pkg::first_free(occupied_ff);
   assign rd_addr = (ghst_pkg::action_type'(req_chan.action) == ghst_pkg::ACT_CREATE)
                  ? free_slot.pos : PW'(req_chan.slot_index - IW'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ghst_pkg::ST_IDLE: if (accept) state_in = ghst_pkg::ST_EXEC;
         ghst_pkg::ST_EXEC: if (exec_fire) state_in = ghst_pkg::ST_IDLE;
         default:           state_in = ghst_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      exec_fire = 1'b0;
      case (state_ff)
         ghst_pkg::ST_IDLE: req_ready = 1'b1;
         ghst_pkg::ST_EXEC: exec_fire = !rsp_valid_ff || rsp_chan.ready;
         default:           req_ready = 1'b0;
      endcase
   end

   assign req_chan.ready = req_ready;

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff   <= ghst_pkg::action_type'(req_chan.action);
         pos_ff      <= rd_addr;
         gen_ff      <= req_chan.slot_generation;
         kind_ff     <= req_chan.kind;
         check_ff    <= req_chan.check_kind;
         in_range_ff <= (req_chan.slot_index != '0) && (req_chan.slot_index <= IW'(SC));
         full_ff     <= !free_slot.found;
         gen_rd_ff   <= gen_mem[rd_addr];
         kind_rd_ff  <= kind_mem[rd_addr];
      end
   end

   assign gen_cur   = gen_vld_ff[pos_ff] ? gen_rd_ff : GW'(1);
   assign gen_next  = ((gen_cur + GW'(1)) == '0) ? GW'(1) : gen_cur + GW'(1);
   assign handle_ok = in_range_ff && occupied_ff[pos_ff] && (gen_cur == gen_ff);

   always_comb begin
      occupied_in   = occupied_ff;
      gen_vld_in    = gen_vld_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_gen_in    = rsp_gen_ff;
      wr_gen        = 1'b0;
      wr_kind       = 1'b0;
      if (exec_fire) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ghst_pkg::STS_OK;
         rsp_idx_in    = '0;
         rsp_gen_in    = '0;
         case (action_ff)
            ghst_pkg::ACT_CREATE: begin
               if (full_ff) begin
                  rsp_status_in = ghst_pkg::STS_FULL;
               end else begin
                  occupied_in[pos_ff] = 1'b1;
                  wr_kind    = 1'b1;
                  rsp_idx_in = IW'(pos_ff) + IW'(1);
                  rsp_gen_in = gen_cur;
               end
            end
            ghst_pkg::ACT_DESTROY: begin
               if (!handle_ok) begin
                  rsp_status_in = ghst_pkg::STS_INVALID;
               end else begin
                  occupied_in[pos_ff] = 1'b0;
                  gen_vld_in[pos_ff]  = 1'b1;
                  wr_gen = 1'b1;
               end
            end
            ghst_pkg::ACT_VALIDATE: begin
               if (!handle_ok)
                  rsp_status_in = ghst_pkg::STS_INVALID;
               else if (check_ff && (kind_rd_ff != kind_ff))
                  rsp_status_in = ghst_pkg::STS_KIND;
            end
            default: begin
               occupied_in = '0;
               gen_vld_in  = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_gen)  gen_mem[pos_ff]  <= gen_next;
      if (wr_kind) kind_mem[pos_ff] <= kind_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ghst_pkg::ST_IDLE;
         occupied_ff  <= '0;
         gen_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occupied_ff  <= occupied_in;
         gen_vld_ff   <= gen_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_gen_ff    <= rsp_gen_in;
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.status            = rsp_status_ff;
   assign rsp_chan.handle_index      = rsp_idx_ff;
   assign rsp_chan.handle_generation = rsp_gen_ff;

   // full only when every slot is taken
   a_full_means_all_taken: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ghst_pkg::ST_EXEC && full_ff) |-> (&occupied_ff))
      else $error("full flagged with a free slot");

   a_clear_frees_all: assert property (@(posedge clock) disable iff (reset)
      (exec_fire && action_ff == ghst_pkg::ACT_CLEAR) |=> (occupied_ff == '0))
      else $error("clear left a slot occupied");

   a_destroy_frees_slot: assert property (@(posedge clock) disable iff (reset)
      (exec_fire && action_ff == ghst_pkg::ACT_DESTROY && handle_ok)
      |=> !occupied_ff[$past(pos_ff)])
      else $error("destroy left slot occupied");

   a_handle_gen_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_idx_ff != '0) |-> (rsp_gen_ff != '0))
      else $error("created handle carries generation zero");

   a_no_accept_in_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ghst_pkg::ST_EXEC) |-> !req_ready)
      else $error("transaction accepted while executing");

endmodule

>>> tb/sv/tb_generational_handle_slot_table_top.sv
`timescale 1ns / 100ps
// Testbench: slot table requests against an in-bench table predictor, responses checked in order.
module tb_generational_handle_slot_table_top;

   localparam int SC           = ghst_pkg::SLOT_COUNT;
   localparam int IW           = ghst_pkg::IDX_W;
   localparam int GW           = ghst_pkg::GEN_BITS;
   localparam int CYCLE_LIMIT  = 1_500_000;
   localparam int RANDOM_ITEMS = 1750;
   localparam int IDLE_PCT     = 21;
   localparam int STALL_CYCLES = 300;
   localparam int GEN_ROUNDS   = 40;

   typedef struct packed {
      ghst_pkg::action_type act;
      logic [IW-1:0]        idx;
      logic [GW-1:0]        gen;
      logic                 kind;
      logic                 chk_kind;
   } slot_req_type;

   typedef struct packed {
      ghst_pkg::status_type status;
      logic [IW-1:0]        idx;
      logic [GW-1:0]        gen;
   } handle_rsp_type;

   logic clock;
   logic reset;

   ghst_req_if req ();
   ghst_rsp_if rsp ();

   generational_handle_slot_table_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp)
   );

   // predicted table contents
   bit          slot_used [SC];
   bit [GW-1:0] slot_gen  [SC];
   bit          slot_kind [SC];

   handle_rsp_type due_results[$];
   handle_rsp_type oldest_due;

   int  mismatches  = 0;
   int  items_sent  = 0;
   int  rsp_checked = 0;
   int  full_seen   = 0;
   int  kind_seen   = 0;
   int  bumps_seen  = 0;
   int  cycle_count = 0;
   int  hold_asked  = 0;
   int  hold_given  = 0;
   int  hold_left   = 0;
   bit  calm        = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit roll_idle();
      return !calm && ($urandom_range(99) < IDLE_PCT);
   endfunction

   function automatic slot_req_type mk_req(ghst_pkg::action_type a, int idx, int gen,
                                           int k, int c);
      slot_req_type r;
      r.act      = a;
      r.idx      = IW'(idx);
      r.gen      = GW'(gen);
      r.kind     = k[0];
      r.chk_kind = c[0];
      return r;
   endfunction

   function automatic void wipe_table();
      for (int i = 0; i < SC; i++) begin
         slot_used[i] = 1'b0;
         slot_gen[i]  = GW'(1);
      end
   endfunction

   // applies one request to the predicted table and returns its response
   function automatic handle_rsp_type table_apply(slot_req_type it);
      handle_rsp_type r;
      int             p;
      bit             hit;
      bit             found;
      r.status = ghst_pkg::STS_OK;
      r.idx    = '0;
      r.gen    = '0;
      p        = 0;
      hit      = 1'b0;
      found    = 1'b0;
      if (it.idx >= 1 && it.idx <= SC) begin
         p   = int'(it.idx) - 1;
         hit = slot_used[p] && (slot_gen[p] == it.gen);
      end
      case (it.act)
         ghst_pkg::ACT_CREATE: begin
            for (int i = 0; i < SC; i++) begin
               if (!found && !slot_used[i]) begin
                  found = 1'b1;
                  p     = i;
               end
            end
            if (found) begin
               slot_used[p] = 1'b1;
               slot_kind[p] = it.kind;
               r.idx        = IW'(p + 1);
               r.gen        = slot_gen[p];
            end else begin
               r.status = ghst_pkg::STS_FULL;
               full_seen++;
            end
         end
         ghst_pkg::ACT_DESTROY: begin
            if (!hit) begin
               r.status = ghst_pkg::STS_INVALID;
            end else begin
               slot_used[p] = 1'b0;
               slot_gen[p]  = slot_gen[p] + 1'b1;
               if (slot_gen[p] == 0)
                  slot_gen[p] = GW'(1);
               bumps_seen++;
            end
         end
         ghst_pkg::ACT_VALIDATE: begin
            if (!hit) begin
               r.status = ghst_pkg::STS_INVALID;
            end else if (it.chk_kind && slot_kind[p] != it.kind) begin
               r.status = ghst_pkg::STS_KIND;
               kind_seen++;
            end
         end
         default: begin
            wipe_table();
         end
      endcase
      return r;
   endfunction

   // random occupied slot, -1 when the table is empty
   function automatic int pick_live();
      int n;
      int k;
      n = 0;
      for (int i = 0; i < SC; i++) n += int'(slot_used[i]);
      if (n == 0) return -1;
      k = $urandom_range(n - 1);
      for (int i = 0; i < SC; i++) begin
         if (slot_used[i]) begin
            if (k == 0) return i;
            k--;
         end
      end
      return -1;
   endfunction

   task automatic send_item(input slot_req_type it);
      while (roll_idle()) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid           <= 1'b1;
      req.action          <= it.act;
      req.slot_index      <= it.idx;
      req.slot_generation <= it.gen;
      req.kind            <= it.kind;
      req.check_kind      <= it.chk_kind;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      due_results = {due_results, table_apply(it)};
      items_sent++;
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
   endtask

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         if (due_results.size() == 0) begin
            mismatches++;
            $display("%0t unexpected transaction: expected none, got status %0d index %0d",
                     $time, rsp.status, rsp.handle_index);
            $display("%0t   and gen %0d", $time, rsp.handle_generation);
         end else begin
            oldest_due = due_results.pop_front();
            rsp_checked++;
            if (rsp.status !== oldest_due.status) begin
               mismatches++;
               $display("%0t status: expected %0d, got %0d",
                        $time, oldest_due.status, rsp.status);
            end
            if (rsp.handle_index !== oldest_due.idx) begin
               mismatches++;
               $display("%0t handle_index: expected %0d, got %0d",
                        $time, oldest_due.idx, rsp.handle_index);
            end
            if (rsp.handle_generation !== oldest_due.gen) begin
               mismatches++;
               $display("%0t handle_generation: expected %0d, got %0d",
                        $time, oldest_due.gen, rsp.handle_generation);
            end
         end
      end
   end

   // receiver: random idling plus long holds on request
   always @(posedge clock) begin
      if (hold_given != hold_asked) begin
         hold_given = hold_asked;
         hold_left  = STALL_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= !roll_idle();
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t timeout with %0d responses outstanding", $time, due_results.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic test_directed_handles();
      send_item(mk_req(ghst_pkg::ACT_CREATE,   0,   0,        0, 0));
      send_item(mk_req(ghst_pkg::ACT_CREATE,   127, 16'hFFFF, 1, 1));
      send_item(mk_req(ghst_pkg::ACT_VALIDATE, 1,   1,        0, 1));
      send_item(mk_req(ghst_pkg::ACT_VALIDATE, 1,   1,        1, 1));
      send_item(mk_req(ghst_pkg::ACT_VALIDATE, 1,   1,        1, 0));
      send_item(mk_req(ghst_pkg::ACT_VALIDATE, 2,   1,        1, 1));
      send_item(mk_req(ghst_pkg::ACT_VALIDATE, 0,   1,        0, 0));
      send_item(mk_req(ghst_pkg::ACT_DESTROY,  0,   1,        0, 0));
      send_item(mk_req(ghst_pkg::ACT_VALIDATE, 65,  1,        0, 0));
      send_item(mk_req(ghst_pkg::ACT_DESTROY,  127, 16'hFFFF, 1, 1));
      send_item(mk_req(ghst_pkg::ACT_VALIDATE, 1,   2,        0, 0));
      send_item(mk_req(ghst_pkg::ACT_VALIDATE, 1,   0,        0, 0));
      send_item(mk_req(ghst_pkg::ACT_DESTROY,  1,   1,        0, 0));
      send_item(mk_req(ghst_pkg::ACT_VALIDATE, 1,   1,        0, 0));
      send_item(mk_req(ghst_pkg::ACT_DESTROY,  1,   1,        0, 0));
      send_item(mk_req(ghst_pkg::ACT_VALIDATE, 64,  1,        0, 1));
      send_item(mk_req(ghst_pkg::ACT_CREATE,   0,   0,        0, 0));
      send_item(mk_req(ghst_pkg::ACT_VALIDATE, 1,   2,        0, 1));
      send_item(mk_req(ghst_pkg::ACT_CLEAR,    127, 16'hFFFF, 1, 1));
      send_item(mk_req(ghst_pkg::ACT_VALIDATE, 2,   1,        1, 0));
      send_item(mk_req(ghst_pkg::ACT_CREATE,   64,  16'h5555, 1, 0));
      send_item(mk_req(ghst_pkg::ACT_DESTROY,  1,   1,        0, 0));
   endtask

   task automatic test_table_full();
      send_item(mk_req(ghst_pkg::ACT_CLEAR, 0, 0, 0, 0));
      for (int i = 0; i < SC; i++)
         send_item(mk_req(ghst_pkg::ACT_CREATE, 0, 0, int'(i[0]), 0));
      send_item(mk_req(ghst_pkg::ACT_CREATE, 0, 0, 1, 1));
      send_item(mk_req(ghst_pkg::ACT_VALIDATE, SC, 1, 1, 1));
      send_item(mk_req(ghst_pkg::ACT_DESTROY, 37, 1, 0, 0));
      send_item(mk_req(ghst_pkg::ACT_CREATE, 0, 0, 0, 0));
      send_item(mk_req(ghst_pkg::ACT_CREATE, 0, 0, 0, 0));
   endtask

   // walk slot one through a run of generations, then check old handles go stale
   task automatic test_generation_steps();
      calm = 1'b1;
      send_item(mk_req(ghst_pkg::ACT_CLEAR, 0, 0, 0, 0));
      for (int n = 0; n < GEN_ROUNDS; n++) begin
         send_item(mk_req(ghst_pkg::ACT_CREATE, 0, 0, 1, 0));
         send_item(mk_req(ghst_pkg::ACT_DESTROY, 1, int'(slot_gen[0]), 0, 0));
      end
      send_item(mk_req(ghst_pkg::ACT_VALIDATE, 1, 1, 1, 1));
      send_item(mk_req(ghst_pkg::ACT_CREATE, 0, 0, 1, 0));
      send_item(mk_req(ghst_pkg::ACT_VALIDATE, 1, int'(slot_gen[0]), 1, 1));
      calm = 1'b0;
   endtask

   task automatic test_backpressure();
      int p;
      hold_asked++;
      for (int i = 0; i < 12; i++) begin
         p = pick_live();
         if (p < 0 || i[0])
            send_item(mk_req(ghst_pkg::ACT_CREATE, 0, 0, $urandom_range(1), 0));
         else
            send_item(mk_req(ghst_pkg::ACT_VALIDATE, p + 1, int'(slot_gen[p]),
                             $urandom_range(1), 1));
      end
   endtask

   task automatic test_drain_pause();
      int p;
      for (int n = 0; n < 3; n++) begin
         for (int i = 0; i < 6; i++) begin
            p = pick_live();
            if (p >= 0 && i[0])
               send_item(mk_req(ghst_pkg::ACT_DESTROY, p + 1, int'(slot_gen[p]), 0, 0));
            else
               send_item(mk_req(ghst_pkg::ACT_CREATE, 0, 0, $urandom_range(1), 0));
         end
         wait_drained();
      end
   endtask

   task automatic test_random_traffic();
      int           create_pct;
      int           r;
      int           p;
      slot_req_type it;
      create_pct = 40;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 150 == 0) create_pct = $urandom_range(15, 70);
         calm = (n >= 700 && n < 900);
         it   = mk_req(ghst_pkg::ACT_CREATE, $urandom_range(127), $urandom_range(16'hFFFF),
                       $urandom_range(1), $urandom_range(1));
         p    = pick_live();
         if ($urandom_range(99) >= create_pct) begin
            r = $urandom_range(99);
            if (r < 2) begin
               it.act = ghst_pkg::ACT_CLEAR;
            end else if (r < 90 && p >= 0) begin
               it.act = (r < 35) ? ghst_pkg::ACT_DESTROY : ghst_pkg::ACT_VALIDATE;
               it.idx = IW'(p + 1);
               if (r < 75)
                  it.gen = slot_gen[p];
               else
                  it.gen = slot_gen[p] + GW'($urandom_range(1, 16'hFFFF));
            end else begin
               it.act = r[0] ? ghst_pkg::ACT_DESTROY : ghst_pkg::ACT_VALIDATE;
            end
         end
         send_item(it);
      end
      calm = 1'b0;
   endtask

   initial begin
      reset               = 1'b1;
      req.valid           = 1'b0;
      req.action          = ghst_pkg::ACT_CREATE;
      req.slot_index      = '0;
      req.slot_generation = '0;
      req.kind            = 1'b0;
      req.check_kind      = 1'b0;
      wipe_table();
      for (int i = 0; i < SC; i++) slot_kind[i] = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_handles();
      test_table_full();
      test_generation_steps();
      test_backpressure();
      test_drain_pause();
      test_random_traffic();

      wait_drained();
      repeat (8) @(posedge clock);
      $display("Ran %0d transactions with %0d responses checked, %0d mismatches.",
               items_sent, rsp_checked, mismatches);
      $display("Saw %0d full-table refusals, %0d kind rejections, %0d generation bumps.",
               full_seen, kind_seen, bumps_seen);
      if (mismatches == 0 && due_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
